/* hdl/sampled_page_hit_counter_assert.svh */
// assertion macros for the sampled page hit counter
`ifndef SAMPLED_PAGE_HIT_COUNTER_ASSERT_SVH
`define SAMPLED_PAGE_HIT_COUNTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge out of reset
`define SPHC_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("sphc check failed: condition");

// consequence holds in the same cycle as the antecedent
`define SPHC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sphc check failed: implication");

`else

`define SPHC_ASSERT_ALWAYS(lbl, expr)
`define SPHC_ASSERT_IMPLY(lbl, ante, cons)

`endif

`endif

/* hdl/sphc_pkg.sv */
// shared types and constants of the sampled page hit counter
`timescale 1ns / 1ps

package sphc_pkg;

	localparam int ADDR_W     = 64;
	localparam int PAGE_W     = 52;
	localparam int PAGE_SHIFT = 12;
	localparam int TAG_W      = 32;
	localparam int TAG_LSB    = 32;
	localparam int HIT_W      = 32;
	localparam int TOTAL_W    = 11;
	localparam int INDEX_W    = 10;

	localparam logic [TAG_W-1:0] TAG_RESET = 32'h0000_4000;

	typedef enum logic [1:0] {
		REQ_RECORD = 2'd0,
		REQ_READ   = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STS_COUNTED  = 3'd0,
		STS_INSERTED = 3'd1,
		STS_FILTERED = 3'd2,
		STS_FULL     = 3'd3,
		STS_DONE     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		FSM_IDLE = 4'b0001,
		FSM_SCAN = 4'b0010,
		FSM_READ = 4'b0100,
		FSM_FIN  = 4'b1000
	} fsm_t;

	typedef struct packed {
		status_t             status;
		logic [PAGE_W-1:0]   page;
		logic [HIT_W-1:0]    hits;
		logic                valid;
	} result_t;

endpackage

/* hdl/sphc_entry_ram.sv */
// single-port-write, single-port-read entry memory with registered read data
`timescale 1ns / 1ps

module sphc_entry_ram
	import sphc_pkg::*;
#(
	parameter int DEPTH  = 1024,
	parameter int AW     = 10,
	parameter int DW     = 84
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/sampled_page_hit_counter.sv */
// top level of the sampled page hit counter
`timescale 1ns / 1ps

// Sampled page hit counter. Each request on the slave stream returns exactly
// one result on the master stream. Occupied entries are always slots
// 0 .. entry_total-1 of one entry memory, filled in order and emptied only
// by a clear. A record request scans the occupied slots one per cycle
// through the memory's single read port, until a hit or the end of the
// occupied slots; a read request reads the indexed slot, and a clear or an
// unknown request goes straight to the result state. One request is
// in flight at a time; the result register lets the next request enter
// while the previous result waits. Clearing only resets the occupancy
// count, so there is no clearing pass after reset.
module sampled_page_hit_counter
	import sphc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 1024,
	parameter int COUNT_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // sample_address[63:0], entry_index[73:64], zero
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // page_number[51:0], hit_count[83:52],
	                               // entry_valid[84], entry_total[95:85]
	output logic [2:0]  m_tuser,   // status[2:0]
	// region tag write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int UW    = $clog2(TABLE_ENTRIES + 1);
	localparam int MEM_W = PAGE_W + COUNT_BITS;

	localparam logic [UW-1:0]         USED_FULL = UW'(TABLE_ENTRIES);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	fsm_t                  state_q;
	logic [UW-1:0]         used_q;
	logic [TAG_W-1:0]      region_tag_q;
	logic [PAGE_W-1:0]     page_q;
	logic                  tag_match_q;
	logic                  rd_valid_q;
	logic [IDX_W-1:0]      cmp_idx_q;
	result_t               res_q;
	result_t               out_q;
	logic [TOTAL_W-1:0]    out_total_q;
	logic                  m_tvalid_q;

	req_t                  in_req;
	logic [ADDR_W-1:0]     in_addr;
	logic [INDEX_W-1:0]    in_index;
	logic                  in_fire;

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [MEM_W-1:0]      mem_wdata;
	logic [IDX_W-1:0]      mem_raddr;
	logic [MEM_W-1:0]      mem_rdata;
	logic [PAGE_W-1:0]     rd_page;
	logic [COUNT_BITS-1:0] rd_hits;
	logic [COUNT_BITS-1:0] hits_inc;

	logic [UW-1:0]         cmp_next;
	logic                  scan_hit;
	logic                  scan_end;
	logic                  out_free;

	assign in_req   = req_t'(s_tuser);
	assign in_addr  = s_tdata[63:0];
	assign in_index = s_tdata[73:64];

	assign s_tready  = (state_q == FSM_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	assign rd_page  = mem_rdata[PAGE_W-1:0];
	assign rd_hits  = mem_rdata[MEM_W-1:PAGE_W];
	assign hits_inc = (rd_hits == COUNT_MAX) ? rd_hits : COUNT_BITS'(rd_hits + 1'b1);

	// slot under compare is occupied and holds the page
	assign cmp_next = UW'(cmp_idx_q) + UW'(1);
	assign scan_hit = (UW'(cmp_idx_q) < used_q) && (rd_page == page_q);
	assign scan_end = (cmp_next >= used_q);

	always_comb begin
		mem_raddr = '0;
		if (state_q == FSM_IDLE) begin
			if (in_req == REQ_READ) begin
				mem_raddr = IDX_W'(in_index);
			end
		end else begin
			mem_raddr = cmp_next[IDX_W-1:0];
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cmp_idx_q;
		mem_wdata = {hits_inc, rd_page};
		if (state_q == FSM_SCAN) begin
			if (scan_hit) begin
				mem_we = 1'b1;
			end else if (scan_end && tag_match_q && used_q != USED_FULL) begin
				mem_we    = 1'b1;
				mem_waddr = used_q[IDX_W-1:0];
				mem_wdata = {COUNT_ONE, page_q};
			end
		end
	end

	sphc_entry_ram #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (IDX_W),
		.DW    (MEM_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FSM_IDLE;
			used_q       <= '0;
			region_tag_q <= TAG_RESET;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				region_tag_q <= cfg_data;
			end
			// a new result replaces one that transfers in the same cycle
			if (state_q == FSM_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				FSM_IDLE: begin
					if (in_fire) begin
						case (in_req)
							REQ_RECORD: state_q <= FSM_SCAN;
							REQ_READ:   state_q <= FSM_READ;
							REQ_CLEAR: begin
								used_q  <= '0;
								state_q <= FSM_FIN;
							end
							default:    state_q <= FSM_FIN;
						endcase
					end
				end
				FSM_SCAN: begin
					if (scan_hit) begin
						state_q <= FSM_FIN;
					end else if (scan_end) begin
						if (tag_match_q && used_q != USED_FULL) begin
							used_q <= used_q + UW'(1);
						end
						state_q <= FSM_FIN;
					end
				end
				FSM_READ: begin
					state_q <= FSM_FIN;
				end
				FSM_FIN: begin
					if (out_free) begin
						state_q <= FSM_IDLE;
					end
				end
				default: state_q <= FSM_IDLE;
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			FSM_IDLE: begin
				cmp_idx_q   <= '0;
				page_q      <= in_addr[PAGE_SHIFT +: PAGE_W];
				tag_match_q <= (in_addr[TAG_LSB +: TAG_W] == region_tag_q);
				rd_valid_q  <= (32'(in_index) < 32'(used_q));
				res_q       <= '{status: STS_DONE, page: '0, hits: '0, valid: 1'b0};
			end
			FSM_SCAN: begin
				cmp_idx_q <= cmp_next[IDX_W-1:0];
				if (scan_hit) begin
					res_q.status <= STS_COUNTED;
				end else if (!tag_match_q) begin
					res_q.status <= STS_FILTERED;
				end else if (used_q == USED_FULL) begin
					res_q.status <= STS_FULL;
				end else begin
					res_q.status <= STS_INSERTED;
				end
			end
			FSM_READ: begin
				if (rd_valid_q) begin
					res_q.page  <= rd_page;
					res_q.hits  <= HIT_W'(rd_hits);
					res_q.valid <= 1'b1;
				end
			end
			FSM_FIN: begin
				if (out_free) begin
					out_q       <= res_q;
					out_total_q <= TOTAL_W'(used_q);
				end
			end
			default: begin
				cmp_idx_q <= '0;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {out_total_q, out_q.valid, out_q.hits, out_q.page};

`include "sampled_page_hit_counter_assert.svh"

	`SPHC_ASSERT_ALWAYS(a_used_bound, used_q <= USED_FULL)
	`SPHC_ASSERT_IMPLY(a_used_step, used_q != $past(used_q),
		used_q == '0 || used_q == $past(used_q) + UW'(1))
	`SPHC_ASSERT_IMPLY(a_valid_only_read, m_tvalid_q && out_q.status != STS_DONE,
		!out_q.valid && out_q.hits == '0)
	`SPHC_ASSERT_IMPLY(a_insert_total, m_tvalid_q && out_q.status == STS_INSERTED,
		out_total_q != '0)

endmodule
